@@ sv/brff_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap range find and fill: shared types and codes
// Item formats, result status codes, operation codes and controller states.
// ----------------------------------------------------------------------------
package brff_pkg;

   localparam logic ACT_FIND = 1'b0;
   localparam logic ACT_FILL = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_BAD_RANGE = 2'd2;

   localparam int unsigned START_W = 12;
   localparam int unsigned END_W   = 13;
   localparam int unsigned POS_W   = 12;

   typedef struct packed {
      logic               action;
      logic [START_W-1:0] range_start;
      logic [END_W-1:0]   range_end;
      logic               bit_value;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [POS_W-1:0] position;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

@@ sv/brff_word_op.sv @@
// ----------------------------------------------------------------------------
// Bitmap word operation
// Masks one bitmap word to the requested range, finds the first matching bit
// counted from the most significant end and builds the filled word.
// ----------------------------------------------------------------------------
module brff_word_op
   import brff_pkg::*;
#(
   parameter int unsigned WORD_BITS = 64,
   parameter int unsigned CW        = 14,
   parameter int unsigned OFF_W     = 6
) (
   input  logic [WORD_BITS-1:0] word,
   input  logic [CW-1:0]        base,
   input  logic [CW-1:0]        range_lo,
   input  logic [CW-1:0]        range_hi,
   input  logic                 bit_value,
   output logic                 hit,
   output logic [OFF_W-1:0]     hit_offset,
   output logic [WORD_BITS-1:0] fill_word
);

   localparam int unsigned OW = $clog2(WORD_BITS + 1);
   localparam logic [CW-1:0] WB_C = CW'(WORD_BITS);

   logic [CW-1:0]        lo_diff;
   logic [CW-1:0]        hi_diff;
   logic [OW-1:0]        lo;
   logic [OW-1:0]        hi;
   logic [WORD_BITS-1:0] in_rng;

   always_comb begin
      lo_diff = range_lo - base;
      hi_diff = range_hi - base;
      if (range_lo <= base) begin
         lo = '0;
      end else if (lo_diff >= WB_C) begin
         lo = OW'(WORD_BITS);
      end else begin
         lo = lo_diff[OW-1:0];
      end
      if (range_hi <= base) begin
         hi = '0;
      end else if (hi_diff >= WB_C) begin
         hi = OW'(WORD_BITS);
      end else begin
         hi = hi_diff[OW-1:0];
      end
   end

   always_comb begin
      hit        = 1'b0;
      hit_offset = '0;
      fill_word  = word;
      for (int j = 0; j < WORD_BITS; j++) begin
         in_rng[j] = (OW'(j) >= lo) && (OW'(j) < hi);
         if (in_rng[j]) begin
            fill_word[WORD_BITS-1-j] = bit_value;
         end
      end
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (in_rng[j] && (word[WORD_BITS-1-j] == bit_value)) begin
            hit        = 1'b1;
            hit_offset = OFF_W'(j);
         end
      end
   end

endmodule

@@ sv/bitmap_range_find_and_fill.sv @@
// ----------------------------------------------------------------------------
// Bitmap range find and fill
// Allocation bitmap in one synchronous memory, walked one word per cycle.
// ----------------------------------------------------------------------------
// A bad range is answered in the cycle after the item is taken.
// A find or fill walks the memory from word 0, one word read a cycle, until a find's hit,
// the word that holds the end of the range or the last word.
// Busy is low during the result strobe, so the next item can be taken as that cycle ends.
// After reset the block clears the memory word by word, busy throughout.
// Results are strobed for one cycle and cannot be stalled.
module bitmap_range_find_and_fill
   import brff_pkg::*;
#(
   parameter int unsigned WORD_BITS = 64,
   parameter int unsigned MAP_WORDS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int unsigned TOTAL_BITS = WORD_BITS * MAP_WORDS;
   localparam int unsigned SUM_W      = $clog2(TOTAL_BITS + WORD_BITS + 1);
   localparam int unsigned CW         = (SUM_W > END_W) ? SUM_W : END_W;
   localparam int unsigned AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int unsigned OFF_W      = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam logic [CW-1:0] TOTAL_C  = CW'(TOTAL_BITS);
   localparam logic [CW-1:0] WB_C     = CW'(WORD_BITS);
   localparam logic [AW-1:0] LAST_W   = AW'(MAP_WORDS - 1);

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic [AW-1:0]        raddr;
   logic [AW-1:0]        waddr;
   logic [WORD_BITS-1:0] wdata;
   logic                 we;

   state_type     state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [CW-1:0] base_ff, base_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic          act_ff, act_in;
   logic          val_ff, val_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic                 accept;
   logic [CW-1:0]        end_ext;
   logic [CW-1:0]        end_sat;
   logic                 bad_range;
   logic                 hit;
   logic [OFF_W-1:0]     hit_offset;
   logic [WORD_BITS-1:0] fill_word;
   logic [CW-1:0]        base_next;
   logic                 last_word;
   logic [AW-1:0]        cur_next;

   brff_word_op #(
      .WORD_BITS (WORD_BITS),
      .CW        (CW),
      .OFF_W     (OFF_W)
   ) u_word_op (
      .word       (rdata_ff),
      .base       (base_ff),
      .range_lo   (lo_ff),
      .range_hi   (hi_ff),
      .bit_value  (val_ff),
      .hit        (hit),
      .hit_offset (hit_offset),
      .fill_word  (fill_word)
   );

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cur_ff  <= cur_in;
      base_ff <= base_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      act_ff  <= act_in;
      val_ff  <= val_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      accept    = start && (state_ff == ST_IDLE);
      end_ext   = CW'(req_item.range_end);
      end_sat   = (end_ext > TOTAL_C) ? TOTAL_C : end_ext;
      bad_range = CW'(req_item.range_start) >= end_sat;
      base_next = base_ff + WB_C;
      last_word = (base_next >= hi_ff) || (cur_ff == LAST_W);
      cur_next  = (cur_ff == LAST_W) ? '0 : cur_ff + AW'(1);

      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      base_in       = base_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      act_in        = act_ff;
      val_in        = val_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      raddr         = '0;
      waddr         = cur_ff;
      wdata         = fill_word;
      we            = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            wdata = '0;
            if (clr_ff == LAST_W) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cur_in  = '0;
               base_in = '0;
               lo_in   = CW'(req_item.range_start);
               hi_in   = end_sat;
               act_in  = req_item.action;
               val_in  = req_item.bit_value;
               if (bad_range) begin
                  rsp_strobe_in   = 1'b1;
                  rsp_in.status   = STATUS_BAD_RANGE;
                  rsp_in.position = '0;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            raddr   = cur_next;
            we      = (act_ff == ACT_FILL);
            cur_in  = cur_next;
            base_in = base_next;
            if ((act_ff == ACT_FIND) && hit) begin
               state_in        = ST_IDLE;
               rsp_strobe_in   = 1'b1;
               rsp_in.status   = STATUS_OK;
               rsp_in.position = POS_W'(base_ff + CW'(hit_offset));
            end else if (last_word) begin
               state_in        = ST_IDLE;
               rsp_strobe_in   = 1'b1;
               rsp_in.status   = (act_ff == ACT_FILL) ? STATUS_OK : STATUS_NOT_FOUND;
               rsp_in.position = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_WALK || (start && state_ff == ST_IDLE)))
      else $error("result strobed without a finished walk or a rejected item");

   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.status == STATUS_OK || rsp_item.status == STATUS_NOT_FOUND
                      || rsp_item.status == STATUS_BAD_RANGE))
      else $error("result carries an undefined status");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> base_ff < hi_ff)
      else $error("walk has passed the end of the range");
`endif

endmodule

@@ bench/bitmap_result_checker.sv @@
// ----------------------------------------------------------------------------
// Bitmap range find and fill: result checker
// Watches the command and result channels, keeps its own copy of the
// allocation bitmap, predicts the result of each accepted item and compares
// every strobed result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bitmap_result_checker
   import brff_pkg::*;
#(
   parameter int unsigned WORD_BITS = 64,
   parameter int unsigned MAP_WORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_item,
   input  logic        rsp_strobe,
   input  rsp_type     rsp_item,
   output int unsigned fail_count,
   output int unsigned outstanding
);

   localparam int unsigned MAP_BITS = WORD_BITS * MAP_WORDS;

   // Index 0 is the top bit of word 0, so the flat array follows bit order.
   logic        bitmap [0:MAP_BITS-1];
   rsp_type     expected_results [$];
   int unsigned error_total;

   function automatic rsp_type find_or_fill(input req_type it);
      int unsigned lo;
      int unsigned hi;
      int unsigned i;
      logic        hit;
      rsp_type     r;
      lo  = 32'(it.range_start);
      hi  = 32'(it.range_end);
      hit = 1'b0;
      if (hi > MAP_BITS) begin
         hi = MAP_BITS;
      end
      r.status   = STATUS_OK;
      r.position = '0;
      if (lo >= hi) begin
         r.status = STATUS_BAD_RANGE;
      end else if (it.action == ACT_FIND) begin
         r.status = STATUS_NOT_FOUND;
         for (i = lo; i < hi && !hit; i++) begin
            if (bitmap[i] == it.bit_value) begin
               hit        = 1'b1;
               r.status   = STATUS_OK;
               r.position = POS_W'(i);
            end
         end
      end else begin
         for (i = lo; i < hi; i++) begin
            bitmap[i] = it.bit_value;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int unsigned k = 0; k < MAP_BITS; k++) begin
            bitmap[k] = 1'b0;
         end
         expected_results.delete();
         error_total = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: status %0d, position %0d",
                      rsp_item.status, rsp_item.position);
               error_total++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
                  error_total++;
               end
               if (rsp_item.position !== want.position) begin
                  $error("position: expected %0d, actual %0d",
                         want.position, rsp_item.position);
                  error_total++;
               end
            end
         end
         if (start && !busy) begin
            expected_results.push_back(find_or_fill(req_item));
         end
      end
      fail_count  <= error_total;
      outstanding <= expected_results.size();
   end

endmodule

@@ bench/tb_bitmap_range_find_and_fill.sv @@
// ----------------------------------------------------------------------------
// Bitmap range find and fill: regression testbench
// Drives a directed set of find and fill commands followed by random ones,
// with random gaps and stretches of back-to-back items, and lets the result
// checker judge every result. A watchdog ends the run if the block stalls.
// ----------------------------------------------------------------------------
module tb_bitmap_range_find_and_fill;
   import brff_pkg::*;

   localparam int unsigned WORD_BITS    = 64;
   localparam int unsigned MAP_WORDS    = 64;
   localparam int unsigned RANDOM_ITEMS = 1728;
   localparam int unsigned STALL_LIMIT  = 2000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_strobe;
   rsp_type     rsp_item;
   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned quiet_cycles;
   int unsigned calm_left;
   req_type     directed [$];

   bitmap_range_find_and_fill #(
      .WORD_BITS(WORD_BITS),
      .MAP_WORDS(MAP_WORDS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   bitmap_result_checker #(
      .WORD_BITS(WORD_BITS),
      .MAP_WORDS(MAP_WORDS)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic req_type make_item(input logic act, input int unsigned lo,
                                         input int unsigned hi, input logic val);
      req_type it;
      it.action      = act;
      it.range_start = START_W'(lo);
      it.range_end   = END_W'(hi);
      it.bit_value   = val;
      return it;
   endfunction

   function automatic req_type random_item();
      int unsigned kind;
      int unsigned lo;
      int unsigned len;
      req_type     it;
      kind         = $urandom_range(0, 99);
      lo           = $urandom_range(0, 4095);
      it.action    = ($urandom_range(0, 99) < 45) ? ACT_FILL : ACT_FIND;
      it.bit_value = 1'($urandom_range(0, 1));
      if (kind < 8) begin
         it.range_start = START_W'(lo);
         it.range_end   = END_W'($urandom_range(0, lo));
      end else if (kind < 14) begin
         it.range_start = START_W'($urandom);
         it.range_end   = END_W'($urandom);
      end else if (kind < 20) begin
         it.range_start = START_W'(lo);
         it.range_end   = END_W'($urandom_range(4096, 8191));
      end else begin
         if (kind < 60) begin
            len = $urandom_range(1, 8);
         end else if (kind < 85) begin
            len = $urandom_range(1, 130);
         end else begin
            len = $urandom_range(1, 4096);
         end
         it.range_start = START_W'(lo);
         it.range_end   = END_W'(lo + len);
      end
      return it;
   endfunction

   function automatic int unsigned draw_gap();
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         calm_left = $urandom_range(20, 60);
      end
      return $urandom_range(0, 3);
   endfunction

   // Start stays high across back-to-back items and is lowered only for a gap or a wait for idle.
   task automatic issue_item(input req_type it, input int unsigned gap,
                             input logic wait_idle);
      if (gap != 0 || wait_idle) begin
         start <= 1'b0;
         if (wait_idle) begin
            do @(posedge clock); while (busy);
         end
         repeat (gap) @(posedge clock);
      end
      req_item <= it;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("bitmap_range_find_and_fill regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned gap;
      logic        wait_idle;
      reset        = 1'b1;
      start        = 1'b0;
      req_item     = '0;
      calm_left    = 0;

      directed.push_back(make_item(ACT_FIND, 0, 4096, 1'b0));
      directed.push_back(make_item(ACT_FIND, 0, 8191, 1'b1));
      directed.push_back(make_item(ACT_FILL, 4095, 4096, 1'b1));
      directed.push_back(make_item(ACT_FIND, 0, 4096, 1'b1));
      directed.push_back(make_item(ACT_FILL, 0, 64, 1'b1));
      directed.push_back(make_item(ACT_FIND, 0, 4096, 1'b0));
      directed.push_back(make_item(ACT_FILL, 100, 8191, 1'b1));
      directed.push_back(make_item(ACT_FIND, 0, 4096, 1'b0));
      directed.push_back(make_item(ACT_FIND, 100, 4096, 1'b0));
      directed.push_back(make_item(ACT_FIND, 200, 200, 1'b0));
      directed.push_back(make_item(ACT_FILL, 4095, 0, 1'b1));
      directed.push_back(make_item(ACT_FILL, 4095, 4095, 1'b0));
      directed.push_back(make_item(ACT_FIND, 0, 0, 1'b1));
      directed.push_back(make_item(ACT_FILL, 0, 4096, 1'b0));
      directed.push_back(make_item(ACT_FIND, 0, 4096, 1'b1));
      directed.push_back(make_item(ACT_FILL, 63, 65, 1'b1));
      directed.push_back(make_item(ACT_FIND, 0, 4096, 1'b1));
      directed.push_back(make_item(ACT_FIND, 64, 65, 1'b1));
      directed.push_back(make_item(ACT_FIND, 63, 65, 1'b0));
      directed.push_back(make_item(ACT_FILL, 0, 1, 1'b0));
      directed.push_back(make_item(ACT_FILL, 0, 1, 1'b1));
      directed.push_back(make_item(ACT_FIND, 0, 1, 1'b1));
      directed.push_back(make_item(ACT_FIND, 4095, 4096, 1'b0));
      directed.push_back(make_item(ACT_FIND, 4095, 8191, 1'b1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[k]) begin
         gap       = draw_gap();
         wait_idle = 1'($urandom_range(0, 1));
         issue_item(directed[k], gap, wait_idle);
      end
      repeat (RANDOM_ITEMS) begin
         gap       = draw_gap();
         wait_idle = 1'($urandom_range(0, 1));
         issue_item(random_item(), gap, wait_idle);
      end
      start <= 1'b0;

      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (MAP_WORDS + 8) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("bitmap_range_find_and_fill regression: pass");
      end else begin
         $display("bitmap_range_find_and_fill regression: fail");
      end
      $finish;
   end

endmodule
